@@ src/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg: predicate stack entailment shared definitions
// Request, comparison and verdict codes, the predicate record and the
// entailment judge used by every stack cell.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_VAR_BITS    = 16;

    localparam int REQ_W = 2;
    localparam int VAR_W = 16;
    localparam int OP_W  = 3;
    localparam int LIT_W = 64;
    localparam int ANS_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVAL = 2'd2;

    localparam logic [OP_W-1:0] OP_EQ  = 3'd0;
    localparam logic [OP_W-1:0] OP_NEQ = 3'd1;
    localparam logic [OP_W-1:0] OP_LT  = 3'd2;
    localparam logic [OP_W-1:0] OP_LTE = 3'd3;
    localparam logic [OP_W-1:0] OP_GT  = 3'd4;
    localparam logic [OP_W-1:0] OP_GTE = 3'd5;

    localparam logic [ANS_W-1:0] V_NONE  = 2'd0;
    localparam logic [ANS_W-1:0] V_TRUE  = 2'd1;
    localparam logic [ANS_W-1:0] V_FALSE = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic [VAR_W-1:0]        var_id;
        logic [OP_W-1:0]         op;
        logic signed [LIT_W-1:0] lit;
    } t_pred;

    typedef struct packed {
        logic push;
        logic pop;
        logic load;
        logic shift;
    } t_cell_ctl;

    // a: stored entry, c: candidate
    function automatic logic [ANS_W-1:0] judge(
        input logic [OP_W-1:0]         aop,
        input logic signed [LIT_W-1:0] a,
        input logic [OP_W-1:0]         cop,
        input logic signed [LIT_W-1:0] c
    );
        logic lt, eq, gt, ge, le, ge_am1, le_ap1;
        logic ent, con;
        lt     = (c < a);
        eq     = (c == a);
        gt     = (c > a);
        ge     = !lt;
        le     = !gt;
        // exact c >= a-1 and c <= a+1; the wrapped case is covered by ge / le
        ge_am1 = ge || (c == (a - 64'sd1));
        le_ap1 = le || (c == (a + 64'sd1));
        ent    = 1'b0;
        con    = 1'b0;
        case (aop)
            OP_EQ: begin
                case (cop)
                    OP_EQ:   begin ent = eq;  con = !eq; end
                    OP_NEQ:  begin ent = !eq; con = eq;  end
                    OP_LT:   begin ent = gt;  con = !gt; end
                    OP_LTE:  begin ent = ge;  con = !ge; end
                    OP_GT:   begin ent = lt;  con = !lt; end
                    OP_GTE:  begin ent = le;  con = !le; end
                    default: ;
                endcase
            end
            OP_NEQ: begin
                con = (cop == OP_EQ) && eq;
                ent = (cop == OP_NEQ) && eq;
            end
            OP_LT: begin
                case (cop)
                    OP_LT:   ent = ge;
                    OP_LTE:  ent = ge_am1;
                    OP_GTE:  con = ge;
                    OP_GT:   con = ge_am1;
                    OP_EQ:   con = ge;
                    OP_NEQ:  ent = ge;
                    default: ;
                endcase
            end
            OP_LTE: begin
                case (cop)
                    OP_LT:   ent = gt;
                    OP_LTE:  ent = ge;
                    OP_GTE:  con = gt;
                    OP_GT:   con = ge;
                    OP_EQ:   con = gt;
                    OP_NEQ:  ent = gt;
                    default: ;
                endcase
            end
            OP_GT: begin
                case (cop)
                    OP_GT:   ent = le;
                    OP_GTE:  ent = le_ap1;
                    OP_LTE:  con = le;
                    OP_LT:   con = le_ap1;
                    OP_EQ:   con = le;
                    OP_NEQ:  ent = le;
                    default: ;
                endcase
            end
            OP_GTE: begin
                case (cop)
                    OP_GT:   ent = lt;
                    OP_GTE:  ent = le;
                    OP_LTE:  con = lt;
                    OP_LT:   con = le;
                    OP_EQ:   con = lt;
                    OP_NEQ:  ent = lt;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (ent) begin
            return V_TRUE;
        end else if (con) begin
            return V_FALSE;
        end
        return V_NONE;
    endfunction

endpackage

@@ src/pse_cell.sv @@
// ----------------------------------------------------------------------------
// pse_cell: one stack slot
// Holds one predicate, shifts it with its neighbors on push and pop, judges
// the broadcast candidate and shifts its verdict toward the top on scan.
// ----------------------------------------------------------------------------
module pse_cell (
    input  logic                    i_clk,
    input  pse_pkg::t_cell_ctl      i_ctl,
    input  pse_pkg::t_pred          i_above,
    input  pse_pkg::t_pred          i_below,
    input  logic [1:0]              i_below_verdict,
    input  pse_pkg::t_pred          i_cand,
    output pse_pkg::t_pred          o_entry,
    output logic [1:0]              o_verdict
);
    import pse_pkg::*;

    t_pred            r_entry;
    logic [ANS_W-1:0] r_verdict;
    logic [ANS_W-1:0] n_verdict;

    always_comb begin
        if (r_entry.valid && (r_entry.var_id == i_cand.var_id)) begin
            n_verdict = judge(r_entry.op, r_entry.lit, i_cand.op, i_cand.lit);
        end else begin
            n_verdict = V_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_above;
        end else if (i_ctl.pop) begin
            r_entry <= i_below;
        end
        if (i_ctl.load) begin
            r_verdict <= n_verdict;
        end else if (i_ctl.shift) begin
            r_verdict <= i_below_verdict;
        end
    end

    assign o_entry   = r_entry;
    assign o_verdict = r_verdict;

endmodule

@@ src/predicate_stack_entailment.sv @@
// ----------------------------------------------------------------------------
// predicate_stack_entailment: bounded predicate stack with entailment queries
// Push, pop and evaluate requests over a row of stack cells, top in cell 0.
// ----------------------------------------------------------------------------
// One request is taken at a time. A push, pop or no-op request goes to the
// result state at acceptance; its result beat is registered once the output
// register is free. An evaluate judges all cells in parallel at acceptance,
// then the verdicts shift up the cell row one cell per cycle toward the top
// cell, until the top cell holds a verdict or all occupied entries have been
// scanned. An invalid candidate or an empty stack skips the scan and answers
// with no verdict. A request may be accepted while the previous result beat
// still waits at the output register; it is held until that beat is taken.
module predicate_stack_entailment #(
    parameter int STACK_DEPTH = pse_pkg::DEF_STACK_DEPTH,
    parameter int VAR_BITS    = pse_pkg::DEF_VAR_BITS,
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [pse_pkg::REQ_W-1:0]        i_req_type,
    input  logic                             i_pred_valid,
    input  logic [pse_pkg::VAR_W-1:0]        i_pred_var,
    input  logic [pse_pkg::OP_W-1:0]         i_pred_op,
    input  logic signed [pse_pkg::LIT_W-1:0] i_pred_lit,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [pse_pkg::ANS_W-1:0]        o_answer,
    output logic [CNT_W-1:0]                 o_stack_depth,
    output logic                             o_push_dropped
);
    import pse_pkg::*;

    localparam int KEY_W = (VAR_BITS < VAR_W) ? VAR_BITS : VAR_W;
    localparam logic [VAR_W-1:0] VAR_MASK = {VAR_W{1'b1}} >> (VAR_W - KEY_W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_left;
    logic [ANS_W-1:0] r_res_answer;
    logic             r_res_dropped;
    logic             r_out_valid;
    logic [ANS_W-1:0] r_out_answer;
    logic [CNT_W-1:0] r_out_depth;
    logic             r_out_dropped;

    logic             w_acc;
    logic             w_out_free;
    t_pred            w_new;
    t_cell_ctl        w_ctl;
    t_pred            w_entry    [STACK_DEPTH];
    logic [ANS_W-1:0] w_verdict  [STACK_DEPTH];
    t_pred            w_above    [STACK_DEPTH];
    t_pred            w_below    [STACK_DEPTH];
    logic [ANS_W-1:0] w_below_v  [STACK_DEPTH];

    assign o_stall    = (r_state != S_IDLE);
    assign w_acc      = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_new.valid  = i_pred_valid;
    assign w_new.var_id = i_pred_var & VAR_MASK;
    assign w_new.op     = i_pred_op;
    assign w_new.lit    = i_pred_lit;

    always_comb begin
        w_ctl       = '0;
        w_ctl.push  = w_acc && (i_req_type == REQ_PUSH) &&
                      (r_count < CNT_W'(STACK_DEPTH));
        w_ctl.pop   = w_acc && (i_req_type == REQ_POP) && (r_count != '0);
        w_ctl.load  = w_acc && (i_req_type == REQ_EVAL);
        w_ctl.shift = (r_state == S_SCAN) && (w_verdict[0] == V_NONE);
    end

    genvar g;
    for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_top
            assign w_above[g] = w_new;
        end else begin : g_mid
            assign w_above[g] = w_entry[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below[g]   = w_entry[g];
            assign w_below_v[g] = V_NONE;
        end else begin : g_inner
            assign w_below[g]   = w_entry[g+1];
            assign w_below_v[g] = w_verdict[g+1];
        end
        pse_cell u_cell (
            .i_clk           (i_clk),
            .i_ctl           (w_ctl),
            .i_above         (w_above[g]),
            .i_below         (w_below[g]),
            .i_below_verdict (w_below_v[g]),
            .i_cand          (w_new),
            .o_entry         (w_entry[g]),
            .o_verdict       (w_verdict[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res_answer  <= V_NONE;
                        r_res_dropped <= 1'b0;
                        r_state       <= S_RES;
                        if (i_req_type == REQ_PUSH) begin
                            if (w_ctl.push) begin
                                r_count <= r_count + CNT_W'(1);
                            end else begin
                                r_res_dropped <= 1'b1;
                            end
                        end else if (w_ctl.pop) begin
                            r_count <= r_count - CNT_W'(1);
                        end else if ((i_req_type == REQ_EVAL) && i_pred_valid &&
                                     (r_count != '0)) begin
                            r_left  <= r_count;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_verdict[0] != V_NONE) begin
                        r_res_answer <= w_verdict[0];
                        r_state      <= S_RES;
                    end else if (r_left == CNT_W'(1)) begin
                        r_state <= S_RES;
                    end else begin
                        r_left <= r_left - CNT_W'(1);
                    end
                end
                S_RES: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_answer  <= r_res_answer;
                        r_out_depth   <= r_count;
                        r_out_dropped <= r_res_dropped;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_answer       = r_out_answer;
    assign o_stack_depth  = r_out_depth;
    assign o_push_dropped = r_out_dropped;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_req_type == REQ_PUSH) && (r_count == CNT_W'(STACK_DEPTH))
        |=> r_res_dropped && (r_state == S_RES))
        else $error("push on full stack not flagged");

    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_left != '0) && (r_left <= r_count))
        else $error("scan window out of range");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_count))
        else $error("stack count moved without a request");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RES) && w_out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("result beat not delivered");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for predicate_stack_entailment
// Streams push, pop, evaluate and no-op requests into the block, predicts
// every result beat from a local copy of the predicate stack and checks the
// beats in order. Runs with no idling, then with sender gaps, receiver
// stalls, and both.
// ----------------------------------------------------------------------------
module tb_top;
    import pse_pkg::*;

    localparam int DEPTH = DEF_STACK_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
    localparam logic [OP_W-1:0]  OP_RSV6 = 3'd6;
    localparam logic [OP_W-1:0]  OP_RSV7 = 3'd7;

    localparam logic signed [LIT_W-1:0] LIT_MIN = 64'h8000_0000_0000_0000;
    localparam logic signed [LIT_W-1:0] LIT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [REQ_W-1:0]        req;
        logic                    pv;
        logic [VAR_W-1:0]        var_id;
        logic [OP_W-1:0]         op;
        logic signed [LIT_W-1:0] lit;
    } t_pred_req;

    typedef struct packed {
        logic [ANS_W-1:0] answer;
        logic [CNT_W-1:0] depth;
        logic             dropped;
    } t_stack_result;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    i_stall        = 1'b0;
    logic [REQ_W-1:0]        i_req_type     = '0;
    logic                    i_pred_valid   = 1'b0;
    logic [VAR_W-1:0]        i_pred_var     = '0;
    logic [OP_W-1:0]         i_pred_op      = '0;
    logic signed [LIT_W-1:0] i_pred_lit     = '0;
    logic                    o_stall;
    logic                    o_valid;
    logic [ANS_W-1:0]        o_answer;
    logic [CNT_W-1:0]        o_stack_depth;
    logic                    o_push_dropped;

    t_pred_req     pending_reqs[$];
    t_stack_result expected_results[$];
    t_pred_req     drv_item;
    t_stack_result got_beat;
    logic          in_taken = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            errors = 0;
    int            plan_depth = 0;
    int            plan_target = DEPTH;

    // predicate stack copy
    logic                    stk_valid[DEPTH];
    logic [VAR_W-1:0]        stk_var[DEPTH];
    logic [OP_W-1:0]         stk_op[DEPTH];
    logic signed [LIT_W-1:0] stk_lit[DEPTH];
    int                      stk_depth = 0;

    predicate_stack_entailment dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_pred_valid   (i_pred_valid),
        .i_pred_var     (i_pred_var),
        .i_pred_op      (i_pred_op),
        .i_pred_lit     (i_pred_lit),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_answer       (o_answer),
        .o_stack_depth  (o_stack_depth),
        .o_push_dropped (o_push_dropped)
    );

    always #1 i_clk = ~i_clk;

    // stored predicate x <aop> a versus candidate x <cop> c
    function automatic logic [ANS_W-1:0] entail_verdict(
        input logic [OP_W-1:0]         aop,
        input logic signed [LIT_W-1:0] a,
        input logic [OP_W-1:0]         cop,
        input logic signed [LIT_W-1:0] c
    );
        logic signed [LIT_W:0] ax, cx;
        logic ge_am1, le_ap1, ent, con;
        ax     = {a[LIT_W-1], a};
        cx     = {c[LIT_W-1], c};
        ge_am1 = (cx >= ax - 65'sd1);
        le_ap1 = (cx <= ax + 65'sd1);
        ent    = 1'b0;
        con    = 1'b0;
        if (aop == OP_EQ) begin
            case (cop)
                OP_EQ:   ent = (a == c);
                OP_NEQ:  ent = (a != c);
                OP_LT:   ent = (a < c);
                OP_LTE:  ent = (a <= c);
                OP_GT:   ent = (a > c);
                OP_GTE:  ent = (a >= c);
                default: ;
            endcase
            con = (cop <= OP_GTE) && !ent;
        end else if (aop == OP_NEQ) begin
            con = (cop == OP_EQ) && (c == a);
            ent = (cop == OP_NEQ) && (c == a);
        end else if (aop == OP_LT || aop == OP_LTE) begin
            case (cop)
                OP_LT:   ent = (aop == OP_LT) ? (c >= a) : (c > a);
                OP_LTE:  ent = (aop == OP_LT) ? ge_am1 : (c >= a);
                OP_GTE:  con = (aop == OP_LT) ? (c >= a) : (c > a);
                OP_GT:   con = (aop == OP_LT) ? ge_am1 : (c >= a);
                OP_EQ:   con = (aop == OP_LT) ? (c >= a) : (c > a);
                OP_NEQ:  ent = (aop == OP_LT) ? (c >= a) : (c > a);
                default: ;
            endcase
        end else if (aop == OP_GT || aop == OP_GTE) begin
            case (cop)
                OP_GT:   ent = (aop == OP_GT) ? (c <= a) : (c < a);
                OP_GTE:  ent = (aop == OP_GT) ? le_ap1 : (c <= a);
                OP_LTE:  con = (aop == OP_GT) ? (c <= a) : (c < a);
                OP_LT:   con = (aop == OP_GT) ? le_ap1 : (c <= a);
                OP_EQ:   con = (aop == OP_GT) ? (c <= a) : (c < a);
                OP_NEQ:  ent = (aop == OP_GT) ? (c <= a) : (c < a);
                default: ;
            endcase
        end
        if (ent) begin
            return V_TRUE;
        end else if (con) begin
            return V_FALSE;
        end
        return V_NONE;
    endfunction

    task automatic apply_request(input t_pred_req r);
        t_stack_result e;
        int            i;
        e.answer  = V_NONE;
        e.dropped = 1'b0;
        case (r.req)
            REQ_PUSH: begin
                if (stk_depth < DEPTH) begin
                    stk_valid[stk_depth] = r.pv;
                    stk_var[stk_depth]   = r.var_id;
                    stk_op[stk_depth]    = r.op;
                    stk_lit[stk_depth]   = r.lit;
                    stk_depth++;
                end else begin
                    e.dropped = 1'b1;
                end
            end
            REQ_POP: begin
                if (stk_depth > 0) stk_depth--;
            end
            REQ_EVAL: begin
                if (r.pv) begin
                    for (i = stk_depth - 1; i >= 0; i--) begin
                        if (stk_valid[i] && stk_var[i] == r.var_id) begin
                            e.answer = entail_verdict(stk_op[i], stk_lit[i], r.op, r.lit);
                            if (e.answer != V_NONE) break;
                        end
                    end
                end
            end
            default: ;
        endcase
        e.depth = stk_depth[CNT_W-1:0];
        expected_results.insert(expected_results.size(), e);
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic queue_req(
        input logic [REQ_W-1:0]        req,
        input logic                    pv,
        input logic [VAR_W-1:0]        var_id,
        input logic [OP_W-1:0]         op,
        input logic signed [LIT_W-1:0] lit
    );
        t_pred_req it;
        it = '{req: req, pv: pv, var_id: var_id, op: op, lit: lit};
        pending_reqs.insert(pending_reqs.size(), it);
        if (req == REQ_PUSH && plan_depth < DEPTH) plan_depth++;
        if (req == REQ_POP && plan_depth > 0) plan_depth--;
    endtask

    // walks the stack depth toward a moving target, with evaluates in between
    task automatic gen_random_item();
        logic [REQ_W-1:0]        req;
        logic                    pv;
        logic [VAR_W-1:0]        var_id;
        logic [OP_W-1:0]         op;
        logic signed [LIT_W-1:0] lit;
        int                      r;
        pv     = ($urandom_range(99) < 85);
        var_id = ($urandom_range(9) == 0) ? VAR_W'($urandom) : VAR_W'($urandom_range(3));
        op     = ($urandom_range(9) == 0) ? OP_W'($urandom_range(7, 6))
                                          : OP_W'($urandom_range(5));
        r = $urandom_range(99);
        if (r < 40) begin
            lit = LIT_W'($urandom_range(8)) - 64'sd4;
        end else if (r < 50) begin
            lit = LIT_MIN + LIT_W'($urandom_range(2));
        end else if (r < 60) begin
            lit = LIT_MAX - LIT_W'($urandom_range(2));
        end else begin
            lit = {$urandom, $urandom};
        end
        r = $urandom_range(99);
        if (r < 40) begin
            req = REQ_EVAL;
        end else if (r < 44) begin
            req = REQ_NOP;
        end else if (plan_depth < plan_target) begin
            req = REQ_PUSH;
        end else if (plan_depth > plan_target) begin
            req = REQ_POP;
        end else if (plan_target == DEPTH && $urandom_range(1) == 1) begin
            req = REQ_PUSH;
        end else if (plan_target == 0 && $urandom_range(1) == 1) begin
            req = REQ_POP;
        end else begin
            r = $urandom_range(99);
            plan_target = (r < 25) ? DEPTH : (r < 40) ? 0 : int'($urandom_range(DEPTH - 1, 1));
            req = REQ_EVAL;
        end
        queue_req(req, pv, var_id, op, lit);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_item = pending_reqs.pop_front();
                i_valid      <= 1'b1;
                i_req_type   <= drv_item.req;
                i_pred_valid <= drv_item.pv;
                i_pred_var   <= drv_item.var_id;
                i_pred_op    <= drv_item.op;
                i_pred_lit   <= drv_item.lit;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: check result beats, then predict accepted request beats
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                got_beat = expected_results.pop_front();
                if (o_answer !== got_beat.answer)
                    report_mismatch($sformatf("answer %0d, expected %0d",
                                              o_answer, got_beat.answer));
                if (o_stack_depth !== got_beat.depth)
                    report_mismatch($sformatf("stack_depth %0d, expected %0d",
                                              o_stack_depth, got_beat.depth));
                if (o_push_dropped !== got_beat.dropped)
                    report_mismatch($sformatf("push_dropped %0b, expected %0b",
                                              o_push_dropped, got_beat.dropped));
            end
        end
        if (i_rst_n && i_valid && !o_stall)
            apply_request('{req: i_req_type, pv: i_pred_valid, var_id: i_pred_var,
                            op: i_pred_op, lit: i_pred_lit});
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty stack, no-op, extremes, exact +/-1 bounds,
        // invalid entries and candidates, reserved comparison codes
        queue_req(REQ_POP,  1'b1, 16'h0000, OP_EQ,   64'sd0);
        queue_req(REQ_EVAL, 1'b1, 16'h0000, OP_EQ,   64'sd0);
        queue_req(REQ_NOP,  1'b1, 16'hFFFF, OP_RSV7, LIT_MAX);
        queue_req(REQ_PUSH, 1'b1, 16'hFFFF, OP_EQ,   LIT_MAX);
        queue_req(REQ_EVAL, 1'b1, 16'hFFFF, OP_GTE,  LIT_MAX);
        queue_req(REQ_EVAL, 1'b1, 16'hFFFF, OP_GT,   LIT_MAX);
        queue_req(REQ_PUSH, 1'b1, 16'h0000, OP_LT,   LIT_MIN + 64'sd1);
        queue_req(REQ_EVAL, 1'b1, 16'h0000, OP_LTE,  LIT_MIN);
        queue_req(REQ_EVAL, 1'b1, 16'h0000, OP_GT,   LIT_MIN);
        queue_req(REQ_PUSH, 1'b1, 16'h0000, OP_GT,   LIT_MAX - 64'sd1);
        queue_req(REQ_EVAL, 1'b1, 16'h0000, OP_GTE,  LIT_MAX);
        queue_req(REQ_EVAL, 1'b1, 16'h0000, OP_LT,   LIT_MAX);
        queue_req(REQ_PUSH, 1'b0, 16'h0000, OP_EQ,   64'sd0);
        queue_req(REQ_EVAL, 1'b1, 16'h0000, OP_EQ,   64'sd0);
        queue_req(REQ_PUSH, 1'b1, 16'h0005, OP_RSV7, 64'sd0);
        queue_req(REQ_EVAL, 1'b1, 16'h0005, OP_EQ,   64'sd0);
        queue_req(REQ_PUSH, 1'b1, 16'h0005, OP_NEQ,  64'sd3);
        queue_req(REQ_EVAL, 1'b1, 16'h0005, OP_RSV6, 64'sd3);
        queue_req(REQ_EVAL, 1'b0, 16'h0005, OP_NEQ,  64'sd3);
        queue_req(REQ_EVAL, 1'b1, 16'h0005, OP_NEQ,  64'sd3);
        queue_req(REQ_PUSH, 1'b1, 16'h0001, OP_LTE,  -64'sd1);
        queue_req(REQ_EVAL, 1'b1, 16'h0001, OP_LT,   64'sd0);
        queue_req(REQ_EVAL, 1'b1, 16'h0001, OP_EQ,   -64'sd1);
        queue_req(REQ_POP,  1'b1, 16'h0000, OP_EQ,   64'sd0);
        queue_req(REQ_EVAL, 1'b1, 16'h0005, OP_EQ,   64'sd3);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            repeat (200) gen_random_item();
            wait_drained();
        end

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("predicate_stack_entailment: match");
        end else begin
            $display("predicate_stack_entailment: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("predicate_stack_entailment: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
src/pse_pkg.sv
src/pse_cell.sv
src/predicate_stack_entailment.sv
verif/tb_top.sv
